// ===== rtl/core/bplc_pkg.sv =====
// Package for the button press length classifier.
// Holds the mode codes, the history mask, the register map and the configuration struct.
// Has no dependencies; every other file but bplc_req_if imports it.
`timescale 1ns / 1ps

package bplc_pkg;

   localparam int HELD_W = 32;
   localparam int STEP_W = 16;
   localparam int HIST_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [HIST_W-1:0] HIST_MASK = 8'b1001_1111;
   localparam logic [HELD_W-1:0] HELD_MAX = {HELD_W{1'b1}};

   localparam logic [STEP_W-1:0] STEP_RESET = 16'd1;

   typedef enum logic [2:0] {
      MODE_NONE        = 3'd0,
      MODE_REL_SHORT   = 3'd1,
      MODE_REL_LONG    = 3'd2,
      MODE_REL_LONGER  = 3'd3,
      MODE_HOLD_LONG   = 3'd4,
      MODE_HOLD_LONGER = 3'd5
   } press_mode_type;

   typedef enum logic [1:0] {
      REG_LONG_THRESHOLD   = 2'd0,
      REG_LONGER_THRESHOLD = 2'd1,
      REG_STEP_AMOUNT      = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [HELD_W-1:0] long_threshold;
      logic [HELD_W-1:0] longer_threshold;
      logic [STEP_W-1:0] step_amount;
   } bplc_cfg_type;

endpackage

// ===== rtl/core/bplc_req_if.sv =====
// Input channel of the button press length classifier: one raw button sample per word.
// Depends on nothing, not even the package.
`timescale 1ns / 1ps

interface bplc_req_if;
   logic valid;
   logic ready;
   logic button_down;

   modport source(output valid, output button_down, input ready);
   modport sink(input valid, input button_down, output ready);
endinterface

// ===== rtl/core/bplc_rsp_if.sv =====
// Result channel of the button press length classifier: held time and press mode per word.
// Uses bplc_pkg for the field widths and the mode type.
`timescale 1ns / 1ps

interface bplc_rsp_if
   import bplc_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [HELD_W-1:0] held_time;
   press_mode_type    press_mode;

   modport source(output valid, output held_time, output press_mode, input ready);
   modport sink(input valid, input held_time, input press_mode, output ready);
endinterface

// ===== rtl/core/button_press_length_classifier.sv =====
// Button press length classifier, top level.
// A sample word is held in the input register; history, held time and mode update as it advances.
// Throughput: one sample per cycle while the result channel does not stall.
// A stalled result register holds the pipeline; the input register frees when it advances.
// Synchronous active-high reset clears history, held time, mode and the valid flags;
// the thresholds reset to 0 and the step amount to 1.
`timescale 1ns / 1ps

module button_press_length_classifier
   import bplc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   bplc_req_if.sink              req_bus,
   bplc_rsp_if.source            rsp_bus
);

   bplc_cfg_type cfg;

   bplc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bplc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== rtl/core/bplc_csr.sv =====
// APB-style configuration registers: the two thresholds and the step amount.
// Uses bplc_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps

module bplc_csr
   import bplc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output bplc_cfg_type          cfg
);

   bplc_cfg_type  cfg_ff;
   bplc_cfg_type  cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_LONG_THRESHOLD:   cfg_in.long_threshold   = csr_pwdata;
            REG_LONGER_THRESHOLD: cfg_in.longer_threshold = csr_pwdata;
            REG_STEP_AMOUNT:      cfg_in.step_amount      = csr_pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_LONG_THRESHOLD:   csr_prdata = cfg_ff.long_threshold;
         REG_LONGER_THRESHOLD: csr_prdata = cfg_ff.longer_threshold;
         REG_STEP_AMOUNT:      csr_prdata = {{(CSR_DATA_W-STEP_W){1'b0}}, cfg_ff.step_amount};
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_threshold   <= '0;
         cfg_ff.longer_threshold <= '0;
         cfg_ff.step_amount      <= STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/bplc_core.sv =====
// Classifier datapath: input register, history/held-time/mode state update and result register.
// Uses bplc_pkg, bplc_req_if and bplc_rsp_if.
`timescale 1ns / 1ps

module bplc_core
   import bplc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  bplc_cfg_type cfg,
   bplc_req_if.sink     req_bus,
   bplc_rsp_if.source   rsp_bus
);

   // Input register.
   logic s1_valid_ff, s1_valid_in;
   logic s1_bit_ff, s1_bit_in;

   // Recurrent state.
   logic [HIST_W-1:0] hist_ff, hist_in;
   logic [HELD_W-1:0] held_ff, held_in;
   press_mode_type    mode_ff, mode_in;

   // Result register.
   logic              out_valid_ff, out_valid_in;
   logic [HELD_W-1:0] out_held_ff, out_held_in;
   press_mode_type    out_mode_ff, out_mode_in;

   logic              adv;
   logic              take;
   logic [HIST_W-1:0] masked;
   logic              stable;
   logic              released;
   logic [HELD_W:0]   sum;
   logic [HELD_W-1:0] held_acc;

   // The compute stage moves when it holds a sample and the result register is free or being emptied.
   assign adv           = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign take          = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !s1_valid_ff || adv;

   assign s1_valid_in = take || (s1_valid_ff && !adv);
   assign s1_bit_in   = take ? req_bus.button_down : s1_bit_ff;

   assign hist_in  = adv ? {hist_ff[HIST_W-2:0], s1_bit_ff} : hist_ff;
   assign masked   = hist_in & HIST_MASK;
   assign stable   = (masked == HIST_MASK);
   assign released = (masked == '0);

   assign sum      = {1'b0, held_ff} + {{(HELD_W+1-STEP_W){1'b0}}, cfg.step_amount};
   assign held_acc = stable ? (sum[HELD_W] ? HELD_MAX : sum[HELD_W-1:0]) : held_ff;

   always_comb begin
      held_in = held_ff;
      mode_in = mode_ff;
      if (adv) begin
         held_in = held_acc;
         if (held_acc >= cfg.long_threshold) begin
            mode_in = MODE_HOLD_LONG;
         end
         if (held_acc >= cfg.longer_threshold) begin
            mode_in = MODE_HOLD_LONGER;
         end
         if (released) begin
            held_in = '0;
            if (held_acc == '0) begin
               mode_in = MODE_NONE;
            end else if (held_acc < cfg.long_threshold) begin
               mode_in = MODE_REL_SHORT;
            end else if (held_acc >= cfg.longer_threshold) begin
               mode_in = MODE_REL_LONGER;
            end else begin
               mode_in = MODE_REL_LONG;
            end
         end
      end
   end

   assign out_valid_in = adv || (out_valid_ff && !rsp_bus.ready);
   assign out_held_in  = adv ? held_in : out_held_ff;
   assign out_mode_in  = adv ? mode_in : out_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hist_ff      <= '0;
         held_ff      <= '0;
         mode_ff      <= MODE_NONE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         hist_ff      <= hist_in;
         held_ff      <= held_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_bit_ff   <= s1_bit_in;
      out_held_ff <= out_held_in;
      out_mode_ff <= out_mode_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.held_time  = out_held_ff;
   assign rsp_bus.press_mode = out_mode_ff;

`ifndef SYNTHESIS
   // A release always leaves the held time cleared.
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      adv && released |=> held_ff == '0)
      else $error("held time not cleared on release");

   // Outside a release the held time never decreases.
   a_held_monotonic: assert property (@(posedge clock) disable iff (reset)
      adv && !released |=> held_ff >= $past(held_ff))
      else $error("held time decreased without a release");

   // The result word always mirrors the state it was computed into.
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      adv |=> out_valid_ff && out_held_ff == held_ff && out_mode_ff == mode_ff)
      else $error("result word differs from updated state");

   // A sample waiting in the input register is neither lost nor changed.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !adv |=> s1_valid_ff && s1_bit_ff == $past(s1_bit_ff))
      else $error("pending sample lost or changed");
`endif

endmodule

// ===== tb/sv/button_press_length_classifier_test.sv =====
// Self-checking testbench for the button press length classifier: drives sample words and
// register writes, predicts each result word and compares it with what the block returns.
// Depends on bplc_pkg, bplc_req_if, bplc_rsp_if and button_press_length_classifier.
`timescale 1ns / 1ps

module button_press_length_classifier_test;
   import bplc_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SEGMENTS_PER_PHASE = 3;
   localparam int SEGMENT_ITEMS = 58;
   localparam int CONFIG_KINDS = 7;
   localparam int WIDE_STEP_PRESS = 20;
   localparam int DIRECTED_COUNT = 25;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = 4'hC;

   typedef struct packed {
      logic [HELD_W-1:0] held_time;
      press_mode_type    press_mode;
   } press_result_type;

   typedef struct packed {
      logic              button_down;
      logic              typed;
      logic [HELD_W-1:0] held_time;
      press_mode_type    press_mode;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bplc_req_if req_bus();
   bplc_rsp_if rsp_bus();

   button_press_length_classifier u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // Shadow copy of the block's registers and state.
   bplc_cfg_type      shadow_cfg = '{long_threshold: '0, longer_threshold: '0,
                                     step_amount: STEP_RESET};
   logic [HIST_W-1:0] press_history = '0;
   logic [HELD_W-1:0] held_count = '0;
   press_mode_type    mode_state = MODE_NONE;

   press_result_type pending_results[$];

   // Typed expectation travelling with the current sample word, if any.
   logic             row_typed;
   press_result_type row_result;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int settings_applied = 0;
   int cycle_count = 0;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{1'b0, 1'b1, 32'd0, MODE_NONE},
      '{1'b1, 1'b1, 32'd0, MODE_HOLD_LONGER},
      '{1'b1, 1'b0, 32'd0, MODE_NONE},
      '{1'b1, 1'b0, 32'd0, MODE_NONE},
      '{1'b1, 1'b0, 32'd0, MODE_NONE},
      '{1'b1, 1'b0, 32'd0, MODE_NONE},
      '{1'b1, 1'b0, 32'd0, MODE_NONE},
      '{1'b1, 1'b0, 32'd0, MODE_NONE},
      '{1'b1, 1'b0, 32'd0, MODE_NONE},
      '{1'b1, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b1, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b1, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE},
      '{1'b0, 1'b0, 32'd0, MODE_NONE}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic press_result_type classify_sample(input logic sample);
      logic [HIST_W-1:0] stable_bits;
      press_result_type  res;
      press_history = {press_history[HIST_W-2:0], sample};
      stable_bits = press_history & HIST_MASK;
      if (stable_bits == HIST_MASK) begin
         if (held_count > HELD_MAX - shadow_cfg.step_amount)
            held_count = HELD_MAX;
         else
            held_count = held_count + shadow_cfg.step_amount;
      end
      // Both compares run on every sample; the release test below has the last word.
      if (held_count >= shadow_cfg.long_threshold)
         mode_state = MODE_HOLD_LONG;
      if (held_count >= shadow_cfg.longer_threshold)
         mode_state = MODE_HOLD_LONGER;
      if (stable_bits == '0) begin
         if (held_count == '0)
            mode_state = MODE_NONE;
         else if (held_count < shadow_cfg.long_threshold)
            mode_state = MODE_REL_SHORT;
         else if (held_count >= shadow_cfg.longer_threshold)
            mode_state = MODE_REL_LONGER;
         else
            mode_state = MODE_REL_LONG;
         held_count = '0;
      end
      res.held_time = held_count;
      res.press_mode = mode_state;
      return res;
   endfunction

   function automatic logic [CSR_ADDR_W-1:0] reg_addr(input reg_index_type idx);
      return {idx, 2'b00};
   endfunction

   task automatic report_mismatch(input string what, input logic [HELD_W-1:0] got,
                                  input logic [HELD_W-1:0] want);
      $display("[%0t] mismatch, %s: got %0h, want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Predict on every accepted sample word, check every accepted result word.
   always @(posedge clock) begin : monitor
      press_result_type want;
      press_result_type predicted;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result word with nothing expected", rsp_bus.held_time, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.held_time !== want.held_time)
                  report_mismatch("held_time", rsp_bus.held_time, want.held_time);
               if (rsp_bus.press_mode !== want.press_mode)
                  report_mismatch("press_mode", HELD_W'(rsp_bus.press_mode),
                                  HELD_W'(want.press_mode));
               results_checked++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted = classify_sample(req_bus.button_down);
            pending_results.push_back(row_typed ? row_result : predicted);
         end
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("button_press_length_classifier_test: errors");
      $finish;
   end

   task automatic send_sample(input logic sample, input logic typed,
                              input press_result_type res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.button_down <= sample;
      row_typed <= typed;
      row_result <= res;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] want_read;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      want_read = '0;
      if (addr == reg_addr(REG_LONG_THRESHOLD)) begin
         shadow_cfg.long_threshold = data;
         want_read = shadow_cfg.long_threshold;
      end else if (addr == reg_addr(REG_LONGER_THRESHOLD)) begin
         shadow_cfg.longer_threshold = data;
         want_read = shadow_cfg.longer_threshold;
      end else if (addr == reg_addr(REG_STEP_AMOUNT)) begin
         shadow_cfg.step_amount = data[STEP_W-1:0];
         want_read = {{(CSR_DATA_W-STEP_W){1'b0}}, shadow_cfg.step_amount};
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      // The address is still on the bus, so the read data shows the register just written.
      @(posedge clock);
      if (csr_prdata !== want_read)
         report_mismatch("register read-back", csr_prdata, want_read);
   endtask

   // Registers are only touched once the block has drained.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      row_typed <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input int kind);
      logic [HELD_W-1:0] long_value;
      logic [HELD_W-1:0] longer_value;
      logic [CSR_DATA_W-1:0] step_value;
      case (kind)
         0: begin
            long_value = '0;
            longer_value = '0;
            step_value = 32'd1;
         end
         1: begin
            long_value = $urandom_range(20, 3);
            longer_value = long_value + $urandom_range(20, 0);
            step_value = 32'd1;
         end
         2: begin
            // Longer threshold below the long one.
            longer_value = $urandom_range(10, 2);
            long_value = longer_value + $urandom_range(10, 1);
            step_value = $urandom_range(3, 1);
         end
         3: begin
            long_value = HELD_MAX;
            longer_value = HELD_MAX;
            step_value = 32'h0000_FFFF;
         end
         4: begin
            long_value = $urandom_range(5, 0);
            longer_value = $urandom_range(5, 0);
            step_value = '0;
         end
         5: begin
            long_value = $urandom;
            longer_value = $urandom;
            step_value = $urandom;
         end
         default: begin
            long_value = $urandom_range(100, 0);
            longer_value = $urandom_range(150, 0);
            step_value = $urandom_range(8, 1);
         end
      endcase
      write_csr(reg_addr(REG_LONG_THRESHOLD), long_value);
      write_csr(reg_addr(REG_LONGER_THRESHOLD), longer_value);
      write_csr(reg_addr(REG_STEP_AMOUNT), step_value);
      settings_applied++;
   endtask

   // Mostly clean presses and releases with the odd bounce, plus some raw noise.
   task automatic run_segment(input int kind, input int item_goal);
      int sent;
      int run_len;
      sent = 0;
      wait_drained();
      apply_setting(kind);
      while (sent < item_goal) begin
         if ($urandom_range(99) < 85) begin
            run_len = $urandom_range(40, 1);
            if (run_len > item_goal - sent) run_len = item_goal - sent;
            repeat (run_len) begin
               send_sample($urandom_range(99) >= 5, 1'b0, '0);
               sent++;
            end
            run_len = $urandom_range(14, 1);
            if (run_len > item_goal - sent) run_len = item_goal - sent;
            repeat (run_len) begin
               send_sample(1'b0, 1'b0, '0);
               sent++;
            end
         end else begin
            run_len = $urandom_range(10, 1);
            if (run_len > item_goal - sent) run_len = item_goal - sent;
            repeat (run_len) begin
               send_sample(1'($urandom_range(1)), 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   initial begin : stimulus
      press_result_type typed_res;
      int phase;
      int seg;
      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.button_down <= 1'b0;
      row_typed <= 1'b0;
      row_result <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows run on the reset values of the registers.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         typed_res.held_time = directed_rows[i].held_time;
         typed_res.press_mode = directed_rows[i].press_mode;
         send_sample(directed_rows[i].button_down, directed_rows[i].typed, typed_res);
      end

      // An unmapped write must change nothing, and the step register keeps only 16 bits.
      wait_drained();
      write_csr(ADDR_UNMAPPED, 32'h1234_5678);
      write_csr(reg_addr(REG_LONG_THRESHOLD), HELD_MAX);
      write_csr(reg_addr(REG_LONGER_THRESHOLD), HELD_MAX);
      write_csr(reg_addr(REG_STEP_AMOUNT), 32'hFFFF_FFFF);
      settings_applied++;

      // One press at the widest step against the largest thresholds.
      repeat (WIDE_STEP_PRESS) send_sample(1'b1, 1'b0, '0);
      repeat (10) send_sample(1'b0, 1'b0, '0);

      for (phase = 0; phase < 4; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 80;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 80;
            end
            default: begin
               send_idle_pct = 35;
               stall_pct = 35;
            end
         endcase
         for (seg = 0; seg < SEGMENTS_PER_PHASE; seg++)
            run_segment((phase * SEGMENTS_PER_PHASE + seg) % CONFIG_KINDS, SEGMENT_ITEMS);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d sample words under %0d register settings and four idle patterns.",
               samples_sent, settings_applied);
      $display("Checked %0d result words, %0d mismatches.", results_checked, error_count);
      if (error_count == 0) begin
         $display("button_press_length_classifier_test: clean");
      end else begin
         $display("button_press_length_classifier_test: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/bplc_pkg.sv
rtl/core/bplc_req_if.sv
rtl/core/bplc_rsp_if.sv
rtl/core/bplc_csr.sv
rtl/core/bplc_core.sv
rtl/core/button_press_length_classifier.sv
tb/sv/button_press_length_classifier_test.sv
